[hdl/fys_pkg.sv]
// ============================================================================
// fys_pkg
// Shared types and constants for the Fisher-Yates shuffle block.
// ============================================================================
package fys_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 64;
    localparam int unsigned WORD_W           = 32;
    localparam int unsigned SEED_W           = 64;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LIMIT,
        ST_DRAW,
        ST_MUL_A,
        ST_MIX_A,
        ST_MUL_B,
        ST_MIX_B,
        ST_CHECK,
        ST_INDEX,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_EMIT_RD,
        ST_EMIT
    } fys_state_t;

    // Remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } fys_div_stat_t;

endpackage

[hdl/fys_mul64.sv]
// ============================================================================
// fys_mul64
// Iterative 64x64 low-half multiplier: one 16x64 partial product per cycle.
// ============================================================================
module fys_mul64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);
    import fys_pkg::*;

    logic [63:0] acc_reg,  acc_next;
    logic [63:0] a_reg,    a_next;
    logic [63:0] b_reg,    b_next;
    logic [2:0]  step_reg, step_next;
    logic        run_reg,  run_next;
    logic [63:0] part;

    // One 16-bit slice of b times a, shifted into place
    assign part = a_reg * {48'd0, b_reg[15:0]};

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        step_next = step_reg;
        run_next  = run_reg;
        if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            step_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            acc_next  = acc_reg + part;
            a_next    = {a_reg[47:0], 16'd0};
            b_next    = {16'd0, b_reg[63:16]};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd3) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = run_reg && (step_reg == 3'd3);
    assign product = acc_reg + part;

endmodule

[hdl/fys_mod64.sv]
// ============================================================================
// fys_mod64
// Restoring remainder of a 64-bit dividend by a 7-bit divisor, one bit a cycle.
// ============================================================================
module fys_mod64 (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [63:0]           dividend,
    input  logic [6:0]            divisor,
    output fys_pkg::fys_div_stat_t stat,
    output logic [6:0]            remainder
);
    import fys_pkg::*;

    logic [63:0] num_reg,  num_next;
    logic [6:0]  rem_reg,  rem_next;
    logic [6:0]  den_reg,  den_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    assign trial = {rem_reg, num_reg[63]};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Shift in one dividend bit, subtract when it fits
            num_next = {num_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = 7'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[6:0];
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[hdl/fisher_yates_shuffle.sv]
// ============================================================================
// fisher_yates_shuffle
// Collects 32-bit words, shuffles them in place and streams them back out.
// ============================================================================
// Usage:
//   s_ channel: one word per transfer, s_final_in marks the last of a set.
//   Loading accepts a word whenever s_valid is high. Words beyond MAX_ELEMENTS are dropped
//   and overflow is raised on every result of that set.
//   On the final word the stored set of n words is shuffled top index down.
//   Each swap runs a bit-serial remainder for the rejection limit, one
//   generator draw (the increment, two 4-step multiplies each launched
//   from a start state, and the limit compare), another bit-serial
//   remainder for the swap index, and two memory reads and two writes.
//   Each rejected draw adds another generator draw.
//   After the last swap (after the transfer for a single-word set) each
//   word in turn is read from the store and loaded into the output
//   register once it is free, m_final_out on the last. A stalled receiver
//   holds it; no new word is taken before the last one is in the register.
//   cfg channel: writing the seed reloads the generator; ready only while
//   the block is loading.
//   Reset clears the fill count, drop flag, seed and generator state.
//   The element store is a single-port RAM with a registered read.
// ============================================================================
module fisher_yates_shuffle #(
    parameter int unsigned MAX_ELEMENTS = fys_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word_in,
    input  logic        s_final_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word_out,
    output logic        m_final_out,
    output logic        m_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import fys_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Element store
    logic [31:0] mem [MAX_ELEMENTS];
    logic [31:0] rd_data;
    logic [IDX_W-1:0] mem_addr;
    logic [31:0]      mem_wdata;
    logic             mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data <= mem[mem_addr];
    end

    fys_state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             drop_reg, drop_next;
    logic [63:0]      prng_reg, prng_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [63:0]      z_reg, z_next;
    logic [31:0]      wi_reg, wi_next;
    logic [6:0]       limrem_reg, limrem_next;
    logic             out_v_reg, out_v_next;
    logic [31:0]      out_w_reg, out_w_next;
    logic             out_f_reg, out_f_next;
    logic             out_o_reg, out_o_next;

    logic             s_fire, m_fire, cfg_fire;
    logic             out_free, last_k;
    logic             mul_start, mul_done;
    logic [63:0]      mul_a, mul_b, mul_p;
    logic             mod_start;
    logic [63:0]      mod_num;
    logic [6:0]       span, mod_rem;
    fys_div_stat_t    mod_stat;
    logic [63:0]      limit;

    // Divisor follows the index that the next swap will use
    assign span     = 7'(i_next) + 7'd1;
    // limit = 2^64-1 - ((2^64-1) mod span)
    assign limit    = 64'hFFFF_FFFF_FFFF_FFFF - {57'd0, limrem_reg};
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !out_v_reg || m_fire;
    assign last_k   = (k_reg == IDX_W'(fill_reg - CNT_W'(1)));

    fys_mul64 u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
    );

    fys_mod64 u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start),
        .dividend(mod_num), .divisor(span), .stat(mod_stat), .remainder(mod_rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_final_in) begin
                    if (fill_reg != '0) state_next = ST_LIMIT;
                    else                state_next = ST_EMIT_RD;
                end
            end
            ST_LIMIT:   if (mod_stat.done) state_next = ST_DRAW;
            ST_DRAW:    state_next = ST_MUL_A;
            ST_MUL_A:   state_next = ST_MIX_A;
            ST_MIX_A:   if (mul_done) state_next = ST_MUL_B;
            ST_MUL_B:   state_next = ST_MIX_B;
            ST_MIX_B:   if (mul_done) state_next = ST_CHECK;
            ST_CHECK:   state_next = (z_reg >= limit) ? ST_DRAW : ST_INDEX;
            ST_INDEX:   if (mod_stat.done) state_next = ST_RD_I;
            ST_RD_I:    state_next = ST_RD_J;
            ST_RD_J:    state_next = ST_WR_I;
            ST_WR_I:    state_next = ST_WR_J;
            ST_WR_J:    state_next = (i_reg == IDX_W'(1)) ? ST_EMIT_RD : ST_LIMIT;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (last_k) state_next = ST_LOAD;
                    else        state_next = ST_EMIT_RD;
                end
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        prng_next   = prng_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        z_next      = z_reg;
        wi_next     = wi_reg;
        limrem_next = limrem_reg;
        out_v_next  = out_v_reg && !m_fire;
        out_w_next  = out_w_reg;
        out_f_next  = out_f_reg;
        out_o_next  = out_o_reg;
        mem_addr    = IDX_W'(fill_reg);
        mem_wdata   = s_word_in;
        mem_we      = 1'b0;
        mul_start   = 1'b0;
        mul_a       = z_reg ^ {30'd0, z_reg[63:30]};
        mul_b       = MIX_MUL_A;
        mod_start   = 1'b0;
        mod_num     = 64'hFFFF_FFFF_FFFF_FFFF;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    if (fill_reg < CNT_W'(MAX_ELEMENTS)) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    // On the final word start the limit for the top index
                    if (s_final_in) begin
                        i_next    = IDX_W'(fill_next - CNT_W'(1));
                        k_next    = '0;
                        mod_start = (fill_reg != '0);
                    end
                end
            end
            ST_LIMIT: begin
                if (mod_stat.done) begin
                    limrem_next = mod_rem;
                end
            end
            ST_DRAW: begin
                prng_next = prng_reg + GOLDEN_GAMMA;
                z_next    = prng_reg + GOLDEN_GAMMA;
            end
            ST_MUL_A: begin
                mul_start = 1'b1;
            end
            ST_MIX_A: begin
                if (mul_done) begin
                    z_next = mul_p;
                end
            end
            ST_MUL_B: begin
                mul_a     = z_reg ^ {27'd0, z_reg[63:27]};
                mul_b     = MIX_MUL_B;
                mul_start = 1'b1;
            end
            ST_MIX_B: begin
                // Final xor-shift
                if (mul_done) begin
                    z_next = mul_p ^ {31'd0, mul_p[63:31]};
                end
            end
            ST_CHECK: begin
                // Reduce an accepted draw to the swap index
                if (z_reg < limit) begin
                    mod_num   = z_reg;
                    mod_start = 1'b1;
                end
            end
            ST_INDEX: begin
                if (mod_stat.done) begin
                    j_next = IDX_W'(mod_rem);
                end
            end
            ST_RD_I: begin
                mem_addr = i_reg;
            end
            ST_RD_J: begin
                mem_addr = j_reg;
                wi_next  = rd_data;
            end
            ST_WR_I: begin
                mem_addr  = i_reg;
                mem_wdata = rd_data;
                mem_we    = 1'b1;
            end
            ST_WR_J: begin
                // Old word i goes to entry j; step i down for the next swap
                mem_addr  = j_reg;
                mem_wdata = wi_reg;
                mem_we    = 1'b1;
                k_next    = '0;
                if (i_reg != IDX_W'(1)) begin
                    i_next    = i_reg - IDX_W'(1);
                    mod_start = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                mem_addr = k_reg;
            end
            ST_EMIT: begin
                mem_addr = k_reg;
                if (out_free) begin
                    out_v_next = 1'b1;
                    out_w_next = rd_data;
                    out_f_next = last_k;
                    out_o_next = drop_reg;
                    k_next     = k_reg + IDX_W'(1);
                    if (last_k) begin
                        fill_next = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (cfg_fire) begin
            prng_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            prng_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            prng_reg  <= prng_next;
            out_v_reg <= out_v_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        z_reg      <= z_next;
        wi_reg     <= wi_next;
        limrem_reg <= limrem_next;
        out_w_reg  <= out_w_next;
        out_f_reg  <= out_f_next;
        out_o_reg  <= out_o_next;
    end

    assign cfg_ready   = (state_reg == ST_LOAD);
    assign m_valid     = out_v_reg;
    assign m_word_out  = out_w_reg;
    assign m_final_out = out_f_reg;
    assign m_overflow  = out_o_reg;

    // Checks
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(s_valid && s_ready && state_reg != ST_LOAD))
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_word_out)))
        else $error("stalled output changed");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("fill count beyond capacity");

endmodule

[verif/tb_fisher_yates_shuffle.sv]
// ----------------------------------------------------------------------------
// tb_fisher_yates_shuffle
// Self-checking bench for the shuffle block: loads word sets of varied size,
// predicts each shuffled set with its own splitmix64 generator and compares
// every output transfer, under random idling and seed changes.
// ----------------------------------------------------------------------------
module tb_fisher_yates_shuffle;

    import fys_pkg::*;

    localparam int unsigned CAP       = 64;
    localparam int unsigned IDLE_GAP  = 200;
    localparam int unsigned WDOG_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        ovf;
    } shuffled_word_t;

    // Predictor of the shuffled sets and the queue of words still owed
    class shuffle_scoreboard;
        logic [31:0]    held [CAP];
        int unsigned    held_count;
        logic [63:0]    gen_state;
        logic           dropped;
        shuffled_word_t owed [$];
        int unsigned    mismatches;
        int unsigned    sets_done;
        int unsigned    words_checked;

        function void clear_all();
            held_count = 0;
            gen_state  = '0;
            dropped    = 1'b0;
            owed.delete();
            mismatches = 0;
        endfunction

        function void load_seed(logic [63:0] seed);
            gen_state = seed;
        endfunction

        function logic [63:0] draw();
            logic [63:0] z;
            gen_state = gen_state + GOLDEN_GAMMA;
            z = gen_state;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        // Note an accepted word; on the final one, shuffle and queue the set
        function void note_word(logic [31:0] word, logic last);
            logic [63:0] span, ceiling, r;
            int unsigned j;
            logic [31:0] tmp;
            shuffled_word_t item;
            if (held_count < CAP) begin
                held[held_count] = word;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            for (int i = int'(held_count) - 1; i > 0; i--) begin
                span    = 64'(i + 1);
                ceiling = 64'hFFFF_FFFF_FFFF_FFFF - (64'hFFFF_FFFF_FFFF_FFFF % span);
                do r = draw(); while (r >= ceiling);
                j       = int'(r % span);
                tmp     = held[i];
                held[i] = held[j];
                held[j] = tmp;
            end
            for (int k = 0; k < int'(held_count); k++) begin
                item.word = held[k];
                item.last = (k + 1 == int'(held_count));
                item.ovf  = dropped;
                owed.push_back(item);
            end
            held_count = 0;
            dropped    = 1'b0;
            sets_done++;
        endfunction

        // Compare one output transfer with the oldest owed word
        function void check_word(logic [31:0] word, logic last, logic ovf);
            shuffled_word_t want;
            words_checked++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output word %h final %b ovf %b",
                             word, last, ovf);
                return;
            end
            want = owed.pop_front();
            if (want.word !== word || want.last !== last || want.ovf !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: want word %h final %b ovf %b, got %h %b %b",
                             want.word, want.last, want.ovf, word, last, ovf);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_word_in;
    logic        s_final_in;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_word_out;
    logic        m_final_out;
    logic        m_overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    shuffle_scoreboard sb;
    bit          rx_idle_on;
    bit          rx_hold_req;
    int unsigned quiet_cycles;
    int unsigned words_sent;

    fisher_yates_shuffle uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word_in   (s_word_in),
        .s_final_in  (s_final_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word_out  (m_word_out),
        .m_final_out (m_final_out),
        .m_overflow  (m_overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Check output transfers and keep the watchdog on accepted traffic
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_word(m_word_out, m_final_out, m_overflow);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("ERROR: watchdog expired, %0d words still owed", sb.owed.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, and a long hold-off on request
    initial begin
        int unsigned burst;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready = 1'b0;
                repeat (3000) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                burst = $urandom_range(1, 7);
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic write_seed(input logic [63:0] seed);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = seed;
        do @(posedge aclk); while (!cfg_ready);
        sb.load_seed(seed);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offer one word, with an optional random gap before it
    task automatic send_word(input logic [31:0] word, input logic last, input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_word_in  = word;
        s_final_in = last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(word, last);
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_set(input int unsigned n, input bit gaps);
        for (int unsigned k = 0; k < n; k++)
            send_word($urandom, k + 1 == n, gaps);
    endtask

    // Wait until every owed word has come out, then let the block settle
    task automatic drain();
        while (sb.owed.size() != 0) @(negedge aclk);
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return CAP + $urandom_range(1, 6);
        if (roll == 1) return CAP;
        return $urandom_range(1, 8);
    endfunction

    initial begin
        sb = new();
        sb.clear_all();
        sb.sets_done = 0;
        sb.words_checked = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_word_in   = '0;
        s_final_in  = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;
        quiet_cycles = 0;
        words_sent  = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, single word, reset seed, all-ones and zero seeds
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b1, 1'b0);
        drain();
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_set(5, 1'b0);
        drain();
        write_seed(64'h0);
        send_set(3, 1'b0);
        drain();

        // Full store plus dropped words, final word itself dropped
        write_seed(64'h0123_4567_89AB_CDEF);
        send_set(CAP + 2, 1'b1);
        drain();

        // Long receiver hold-off while words keep coming
        rx_hold_req = 1'b1;
        send_set(4, 1'b0);
        send_set(6, 1'b0);
        send_set(3, 1'b0);
        drain();

        // Random sets, reseeding now and then between them
        while (words_sent < 310) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_seed({$urandom, $urandom});
            end
            send_set(pick_size(), 1'b1);
        end

        // Final stretch without idling on either side
        rx_idle_on = 1'b0;
        drain();
        write_seed(64'h8000_0000_0000_0000);
        while (words_sent < 370) send_set($urandom_range(1, 8), 1'b0);
        drain();

        $display("Covered %0d words in %0d sets, %0d output words checked,",
                 words_sent, sb.sets_done, sb.words_checked);
        $display("including single-word sets, full stores with drops and reseeds.");
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("ERROR: %0d mismatches, %0d words still owed",
                     sb.mismatches, sb.owed.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
